// ----- sv/sts_pkg.sv -----
package sts_pkg;

	localparam int MAX_TEXT = 4096;
	localparam int POS_W    = 13;
	localparam int START_W  = 12;
	localparam int LEN_W    = 13;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [2:0] {
		KIND_IDENT    = 3'd0,
		KIND_STRING   = 3'd1,
		KIND_LPAREN   = 3'd2,
		KIND_RPAREN   = 3'd3,
		KIND_OTHER    = 3'd4,
		KIND_END      = 3'd5,
		KIND_UNCLOSED = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_STRING = 2'd2
	} mode_t;

	typedef struct packed {
		kind_t              kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
	} tok_t;

	typedef struct packed {
		tok_t tok_a;
		tok_t tok_b;
		logic two;
	} entry_t;

endpackage

// ----- sv/sts_front.sv -----
module sts_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            text_valid,
	input  logic [7:0]      text_byte,
	output logic            text_stall,
	input  logic            q_full,
	output logic            push,
	output sts_pkg::entry_t push_entry
);

	sts_pkg::mode_t                     mode_q, mode_d;
	logic                               single_q, single_d;
	logic [sts_pkg::POS_W-1:0]          pos_q, pos_d;
	logic [sts_pkg::START_W-1:0]        start_q, start_d;
	logic [sts_pkg::LEN_W-1:0]          len_q, len_d;

	logic                               accept;
	logic                               is_letter, is_digit, is_quote, is_blank;
	logic [sts_pkg::START_W-1:0]        pos_start, next_start;
	logic [sts_pkg::LEN_W-1:0]          grown;
	logic [sts_pkg::POS_W-1:0]          pos_inc;
	logic [7:0]                         close_ch;
	logic                               flush_v, own_v;
	sts_pkg::tok_t                      flush_tok, own_tok;

	assign text_stall = q_full;
	assign accept     = text_valid && !q_full;

	assign is_letter = (text_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], sts_pkg::CH_UNDER});
	assign is_digit  = (text_byte inside {[8'h30:8'h39]});
	assign is_quote  = (text_byte == sts_pkg::CH_SQUOTE) || (text_byte == sts_pkg::CH_DQUOTE);
	assign is_blank  = (text_byte == sts_pkg::CH_SPACE) || (text_byte == sts_pkg::CH_TAB);
	assign close_ch  = single_q ? sts_pkg::CH_SQUOTE : sts_pkg::CH_DQUOTE;

	assign pos_start = (pos_q >= sts_pkg::POS_W'(sts_pkg::MAX_TEXT))
		? sts_pkg::START_W'(sts_pkg::MAX_TEXT - 1) : pos_q[sts_pkg::START_W-1:0];
	assign next_start = (pos_q >= sts_pkg::POS_W'(sts_pkg::MAX_TEXT - 1))
		? sts_pkg::START_W'(sts_pkg::MAX_TEXT - 1)
		: pos_q[sts_pkg::START_W-1:0] + sts_pkg::START_W'(1);
	assign grown = (len_q < sts_pkg::LEN_W'(sts_pkg::MAX_TEXT))
		? len_q + sts_pkg::LEN_W'(1) : len_q;
	assign pos_inc = (pos_q < sts_pkg::POS_W'(sts_pkg::MAX_TEXT))
		? pos_q + sts_pkg::POS_W'(1) : pos_q;

	always_comb begin
		mode_d    = mode_q;
		single_d  = single_q;
		pos_d     = pos_inc;
		start_d   = start_q;
		len_d     = len_q;
		flush_v   = 1'b0;
		own_v     = 1'b0;
		flush_tok = '{kind: sts_pkg::KIND_IDENT, start: start_q, length: len_q};
		own_tok   = '{kind: sts_pkg::KIND_OTHER, start: pos_start, length: sts_pkg::LEN_W'(1)};

		if (text_byte == sts_pkg::CH_NUL) begin
			if (mode_q == sts_pkg::MODE_IDENT) begin
				flush_v = 1'b1;
			end else if (mode_q == sts_pkg::MODE_STRING) begin
				flush_v        = 1'b1;
				flush_tok.kind = sts_pkg::KIND_UNCLOSED;
			end
			own_v          = 1'b1;
			own_tok.kind   = sts_pkg::KIND_END;
			own_tok.length = '0;
			mode_d         = sts_pkg::MODE_IDLE;
			single_d       = 1'b0;
			pos_d          = '0;
			start_d        = '0;
			len_d          = '0;
		end else if (mode_q == sts_pkg::MODE_STRING) begin
			if (text_byte == close_ch) begin
				own_v        = 1'b1;
				own_tok.kind = sts_pkg::KIND_STRING;
				own_tok.start = start_q;
				own_tok.length = len_q;
				mode_d       = sts_pkg::MODE_IDLE;
			end else begin
				len_d = grown;
			end
		end else if (mode_q == sts_pkg::MODE_IDENT && (is_letter || is_digit)) begin
			len_d = grown;
		end else begin
			flush_v = (mode_q == sts_pkg::MODE_IDENT);
			mode_d  = sts_pkg::MODE_IDLE;
			if (is_blank) begin
				own_v = 1'b0;
			end else if (is_letter) begin
				mode_d  = sts_pkg::MODE_IDENT;
				start_d = pos_start;
				len_d   = sts_pkg::LEN_W'(1);
			end else if (is_quote) begin
				mode_d   = sts_pkg::MODE_STRING;
				single_d = (text_byte == sts_pkg::CH_SQUOTE);
				start_d  = next_start;
				len_d    = '0;
			end else if (text_byte == sts_pkg::CH_LPAREN) begin
				own_v        = 1'b1;
				own_tok.kind = sts_pkg::KIND_LPAREN;
			end else if (text_byte == sts_pkg::CH_RPAREN) begin
				own_v        = 1'b1;
				own_tok.kind = sts_pkg::KIND_RPAREN;
			end else begin
				own_v = 1'b1;
			end
		end
	end

	assign push             = accept && (flush_v || own_v);
	assign push_entry.tok_a = flush_v ? flush_tok : own_tok;
	assign push_entry.tok_b = own_tok;
	assign push_entry.two   = flush_v && own_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= sts_pkg::MODE_IDLE;
			single_q <= 1'b0;
			pos_q    <= '0;
			start_q  <= '0;
			len_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			single_q <= single_d;
			pos_q    <= pos_d;
			start_q  <= start_d;
			len_q    <= len_d;
		end
	end

endmodule

// ----- sv/sts_queue.sv -----
module sts_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sts_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output sts_pkg::entry_t head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sts_pkg::entry_t    slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- sv/sts_back.sv -----
module sts_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  sts_pkg::entry_t             head_entry,
	output logic                        pop,
	output logic                        token_valid,
	input  logic                        token_stall,
	output logic [2:0]                  token_kind,
	output logic [sts_pkg::START_W-1:0] token_start,
	output logic [sts_pkg::LEN_W-1:0]   token_length,
	output logic                        last_of_run
);

	logic          valid_q, second_q, last_q;
	sts_pkg::tok_t tok_q;
	logic          load, first_of_two;

	assign load         = !valid_q || !token_stall;
	assign first_of_two = head_entry.two && !second_q;
	assign pop          = load && head_valid && !first_of_two;

	// hold the word while stalled, else advance through the head entry
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			tok_q  <= (second_q) ? head_entry.tok_b : head_entry.tok_a;
			last_q <= !first_of_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q  <= head_valid;
			if (head_valid) begin
				second_q <= first_of_two;
			end
		end
	end

	assign token_valid  = valid_q;
	assign token_kind   = tok_q.kind;
	assign token_start  = tok_q.start;
	assign token_length = tok_q.length;
	assign last_of_run  = last_q;

endmodule

// ----- sv/shell_token_scanner_top.sv -----
// Streaming shell command-line tokenizer. One text byte is taken per cycle
// (text_valid/text_stall); a 0 byte ends the text, flushes any open token,
// reports an unclosed string and gives an end token. Each token leaves as one
// word on token_valid/token_stall with kind, start and length; last_of_run
// marks the final token a byte caused. The front scanner classifies a byte in
// the cycle it is taken and queues up to two tokens as one entry; the back
// end sends one word per cycle while token_stall is low; two tokens from
// one byte leave as two words. A byte's first word goes via a queue slot
// and the back-end output register. Input stalls only when the
// QUEUE_DEPTH-entry queue is full. Positions saturate at 4096, start at 4095.
module shell_token_scanner_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [2:0]  token_kind,
	output logic [11:0] token_start,
	output logic [12:0] token_length,
	output logic        last_of_run
);

	logic            q_full, push, pop, head_valid;
	sts_pkg::entry_t push_entry, head_entry;

	sts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_byte  (text_byte),
		.text_stall (text_stall),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	sts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	sts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_BYTES = 1320;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		sts_pkg::kind_t              kind;
		logic [sts_pkg::START_W-1:0] start;
		logic [sts_pkg::LEN_W-1:0]   length;
		logic                        last;
	} token_word_t;

	class token_ledger;
		token_word_t                 pending_tokens[$];
		sts_pkg::mode_t              mode = sts_pkg::MODE_IDLE;
		bit                          quote_single = 1'b0;
		logic [sts_pkg::POS_W-1:0]   pos = '0;
		logic [sts_pkg::START_W-1:0] open_start = '0;
		logic [sts_pkg::LEN_W-1:0]   open_length = '0;
		int                          errors = 0;

		function int pending_count();
			return pending_tokens.size();
		endfunction

		function void clear_state();
			mode = sts_pkg::MODE_IDLE;
			quote_single = 1'b0;
			pos = '0;
			open_start = '0;
			open_length = '0;
		endfunction

		function logic [sts_pkg::START_W-1:0] clamp(int p);
			return (p >= sts_pkg::MAX_TEXT) ? sts_pkg::START_W'(sts_pkg::MAX_TEXT - 1)
				: sts_pkg::START_W'(p);
		endfunction

		function bit is_letter(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == sts_pkg::CH_UNDER;
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function void add(sts_pkg::kind_t k, logic [sts_pkg::START_W-1:0] s,
				logic [sts_pkg::LEN_W-1:0] l);
			token_word_t w;
			w.kind = k;
			w.start = s;
			w.length = l;
			w.last = 1'b0;
			pending_tokens.push_back(w);
		endfunction

		function void grow();
			if (open_length < sts_pkg::MAX_TEXT)
				open_length++;
		endfunction

		function void take_byte(logic [7:0] b);
			int         first;
			logic [7:0] closer;
			bit         consumed;
			first = pending_tokens.size();
			consumed = 1'b0;
			if (b == sts_pkg::CH_NUL) begin
				if (mode == sts_pkg::MODE_IDENT)
					add(sts_pkg::KIND_IDENT, open_start, open_length);
				else if (mode == sts_pkg::MODE_STRING)
					add(sts_pkg::KIND_UNCLOSED, open_start, open_length);
				add(sts_pkg::KIND_END, clamp(int'(pos)), '0);
				pending_tokens[pending_tokens.size() - 1].last = 1'b1;
				clear_state();
				return;
			end
			if (mode == sts_pkg::MODE_STRING) begin
				closer = quote_single ? sts_pkg::CH_SQUOTE : sts_pkg::CH_DQUOTE;
				if (b == closer) begin
					add(sts_pkg::KIND_STRING, open_start, open_length);
					mode = sts_pkg::MODE_IDLE;
				end else begin
					grow();
				end
			end else begin
				if (mode == sts_pkg::MODE_IDENT) begin
					if (is_letter(b) || is_digit(b)) begin
						grow();
						consumed = 1'b1;
					end else begin
						add(sts_pkg::KIND_IDENT, open_start, open_length);
						mode = sts_pkg::MODE_IDLE;
					end
				end
				if (!consumed) begin
					if (is_letter(b)) begin
						mode = sts_pkg::MODE_IDENT;
						open_start = clamp(int'(pos));
						open_length = sts_pkg::LEN_W'(1);
					end else if (b == sts_pkg::CH_SQUOTE || b == sts_pkg::CH_DQUOTE) begin
						mode = sts_pkg::MODE_STRING;
						quote_single = (b == sts_pkg::CH_SQUOTE);
						open_start = clamp(int'(pos) + 1);
						open_length = '0;
					end else if (b == sts_pkg::CH_LPAREN) begin
						add(sts_pkg::KIND_LPAREN, clamp(int'(pos)), sts_pkg::LEN_W'(1));
					end else if (b == sts_pkg::CH_RPAREN) begin
						add(sts_pkg::KIND_RPAREN, clamp(int'(pos)), sts_pkg::LEN_W'(1));
					end else if (b != sts_pkg::CH_SPACE && b != sts_pkg::CH_TAB) begin
						add(sts_pkg::KIND_OTHER, clamp(int'(pos)), sts_pkg::LEN_W'(1));
					end
				end
			end
			if (pos < sts_pkg::MAX_TEXT)
				pos++;
			if (pending_tokens.size() > first)
				pending_tokens[pending_tokens.size() - 1].last = 1'b1;
		endfunction

		function void match_token(logic [2:0] kind, logic [sts_pkg::START_W-1:0] start,
				logic [sts_pkg::LEN_W-1:0] length, logic last);
			token_word_t want;
			if (pending_tokens.size() == 0) begin
				$error("token_kind: no word expected, got %0d", kind);
				errors++;
				return;
			end
			want = pending_tokens.pop_front();
			if (kind !== want.kind) begin
				$error("token_kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (start !== want.start) begin
				$error("token_start: expected %0d, got %0d", want.start, start);
				errors++;
			end
			if (length !== want.length) begin
				$error("token_length: expected %0d, got %0d", want.length, length);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_run: expected %0d, got %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_stall;
	logic [7:0]  text_byte = '0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [2:0]  token_kind;
	logic [11:0] token_start;
	logic [12:0] token_length;
	logic        last_of_run;

	token_ledger ledger = new;
	bit          quiet = 1'b0;
	int          hold_requests = 0;
	int          items_sent = 0;

	shell_token_scanner_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_byte    (text_byte),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// receive side: check accepted words, then pick the next stall
	initial begin
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (token_valid && !token_stall)
				ledger.match_token(token_kind, token_start, token_length, last_of_run);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				token_stall <= 1'b1;
			end else begin
				token_stall <= !quiet && ($urandom_range(99) < 21);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (!quiet)
			while ($urandom_range(99) < 21)
				gap++;
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (text_stall);
		ledger.take_byte(b);
		items_sent++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		int n;
		n = $urandom_range(52);
		if (n < 26)
			return 8'("a" + n);
		else if (n < 52)
			return 8'("A" + n - 26);
		return sts_pkg::CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_word_char();
		if ($urandom_range(2) == 0)
			return 8'("0" + $urandom_range(9));
		return rand_letter();
	endfunction

	task automatic send_command();
		logic [7:0] quote;
		logic [7:0] c;
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(7))
				0, 1: begin
					send_byte(rand_letter());
					repeat ($urandom_range(0, 8)) send_byte(rand_word_char());
				end
				2: begin
					quote = $urandom_range(1) ? sts_pkg::CH_SQUOTE : sts_pkg::CH_DQUOTE;
					send_byte(quote);
					repeat ($urandom_range(0, 8)) begin
						c = 8'($urandom_range(1, 255));
						if (c == quote)
							c = sts_pkg::CH_SPACE;
						send_byte(c);
					end
					if ($urandom_range(9) != 0)
						send_byte(quote);
				end
				3: send_byte(sts_pkg::CH_LPAREN);
				4: send_byte(sts_pkg::CH_RPAREN);
				5: send_byte($urandom_range(1) ? sts_pkg::CH_SPACE : sts_pkg::CH_TAB);
				6: send_byte(8'($urandom_range(1, 255)));
				default: send_byte(8'("0" + $urandom_range(9)));
			endcase
		end
		send_byte(sts_pkg::CH_NUL);
	endtask

	initial begin
		int  base;
		int  progress;
		bit  held;
		bit  paused;
		held = 1'b0;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_string("_Zz09()\t 'a\"\tb'\"x'");
		send_byte(sts_pkg::CH_NUL);
		send_byte(sts_pkg::CH_NUL);
		send_string("q");
		send_byte(sts_pkg::CH_NUL);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_string("9~");
		send_byte(8'h01);
		send_byte(sts_pkg::CH_NUL);

		base = items_sent;
		while (items_sent - base < RANDOM_BYTES) begin
			progress = items_sent - base;
			quiet = (progress >= 600 && progress < 800);
			if (!held && progress >= 300) begin
				held = 1'b1;
				hold_requests++;
			end
			if (!paused && progress >= 1000) begin
				paused = 1'b1;
				text_valid <= 1'b0;
				do @(posedge clk); while (ledger.pending_count() != 0);
			end
			if ($urandom_range(99) < 85)
				send_command();
			else
				repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
		end
		quiet = 1'b0;

		text_valid <= 1'b0;
		do @(posedge clk); while (ledger.pending_count() != 0);
		repeat (10) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending_count() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
